>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, masked while reset is asserted.
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/gesd_pkg.sv
package gesd_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_VERTEX = 2'd1,
        STATUS_FULL       = 2'd2
    } status_t;

    // Opcode carried in the func field
    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_WALK = 1'b1;

    // Address source for the list head read port
    typedef enum logic [1:0] {
        HSEL_FROM,
        HSEL_TO,
        HSEL_CUR
    } head_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ADD_LINK,
        ST_ADD_RD_REV,
        ST_ADD_LINK_REV,
        ST_EMIT_ONE,
        ST_POP,
        ST_HEAD,
        ST_FETCH,
        ST_EXAM,
        ST_EMIT_LAST
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic      load;
        logic      status_wr;
        status_t   status_code;
        logic      head_rd;
        head_sel_t head_sel;
        logic      link;
        logic      link_rev;
        logic      walk_init;
        logic      pop;
        logic      edge_rd_head;
        logic      edge_rd_next;
        logic      visit;
        logic      emit_single;
        logic      emit_last;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_walk;
        logic from_bad;
        logic to_bad;
        logic table_full;
        logic undirected;
        logic stack_empty;
        logic head_null;
        logic nb_seen;
        logic next_null;
        logic out_free;
    } flags_t;

endpackage

>>> sv/graph_edge_store_dfs_walk.sv
// Channel   | Handshake             | Payload
// ----------+-----------------------+---------------------------------------------------
// input     | s_valid / s_ready     | s_func, s_from_vertex, s_to_vertex
// result    | m_valid / m_ready     | m_status, m_visited_vertex, m_last, m_edge_total
// config    | psel/penable/pwrite   | paddr, pwdata, prdata (pready tied high)
//
// Add edge: check, link, then load the result; undirected mode adds a reverse head read
// and link, and a rejected edge goes from check to result. Walk: each popped vertex costs
// a stack pop, head read and edge fetch, each edge followed an examine and edge table read.
// Reset (aresetn low, synchronous) empties all lists and the edge count; no clearing pass.
// A stalled result channel holds the walk at its next new vertex; the next item is taken as soon
// as the last result of the current one sits in the output register.
module graph_edge_store_dfs_walk #(
    parameter int MAX_VERTICES = 16,
    parameter int MAX_EDGES    = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input transactions
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_func,
    input  logic [7:0]                         s_from_vertex,
    input  logic [7:0]                         s_to_vertex,
    // result transactions
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_status,
    output logic [$clog2(MAX_VERTICES)-1:0]    m_visited_vertex,
    output logic                               m_last,
    output logic [$clog2(MAX_EDGES+1)-1:0]     m_edge_total,
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    // Register index taken from the word address
    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic REG_UNDIRECTED   = 1'b1;

    logic [4:0] vertex_count_reg;
    logic       undirected_reg;
    logic       cfg_write;

    gesd_pkg::cmd_t   cmd;
    gesd_pkg::flags_t flags;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Config writes must land only while the block is idle; the block does not enforce it, so no hold-off here.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= 5'd16;
            undirected_reg   <= 1'b0;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_VERTEX_COUNT: vertex_count_reg <= pwdata[4:0];
                REG_UNDIRECTED:   undirected_reg   <= pwdata[0];
                default:          vertex_count_reg <= vertex_count_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_VERTEX_COUNT: prdata = {27'd0, vertex_count_reg};
            REG_UNDIRECTED:   prdata = {31'd0, undirected_reg};
            default:          prdata = '0;
        endcase
    end

    // Sequencer: decides which datapath step runs each cycle
    gesd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .flags    (flags),
        .cmd      (cmd)
    );

    // Edge store, walk stack, visited map and result register
    gesd_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .flags            (flags),
        .s_func           (s_func),
        .s_from_vertex    (s_from_vertex),
        .s_to_vertex      (s_to_vertex),
        .vertex_count     (vertex_count_reg),
        .undirected_mode  (undirected_reg),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_visited_vertex (m_visited_vertex),
        .m_last           (m_last),
        .m_edge_total     (m_edge_total)
    );

endmodule

>>> sv/gesd_ctrl.sv
`include "assert_macros.svh"

module gesd_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  gesd_pkg::flags_t flags,
    output gesd_pkg::cmd_t   cmd
);

    gesd_pkg::state_t state_reg;
    gesd_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gesd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gesd_pkg::ST_IDLE: begin
                if (in_valid) state_next = gesd_pkg::ST_CHECK;
            end
            gesd_pkg::ST_CHECK: begin
                if (flags.is_walk) begin
                    state_next = flags.from_bad ? gesd_pkg::ST_EMIT_ONE : gesd_pkg::ST_POP;
                end else if (flags.from_bad || flags.to_bad || flags.table_full) begin
                    state_next = gesd_pkg::ST_EMIT_ONE;
                end else begin
                    state_next = gesd_pkg::ST_ADD_LINK;
                end
            end
            gesd_pkg::ST_ADD_LINK: begin
                state_next = flags.undirected ? gesd_pkg::ST_ADD_RD_REV : gesd_pkg::ST_EMIT_ONE;
            end
            gesd_pkg::ST_ADD_RD_REV:   state_next = gesd_pkg::ST_ADD_LINK_REV;
            gesd_pkg::ST_ADD_LINK_REV: state_next = gesd_pkg::ST_EMIT_ONE;
            gesd_pkg::ST_EMIT_ONE: begin
                if (flags.out_free) state_next = gesd_pkg::ST_IDLE;
            end
            gesd_pkg::ST_POP: begin
                state_next = flags.stack_empty ? gesd_pkg::ST_EMIT_LAST : gesd_pkg::ST_HEAD;
            end
            gesd_pkg::ST_HEAD: state_next = gesd_pkg::ST_FETCH;
            gesd_pkg::ST_FETCH: begin
                state_next = flags.head_null ? gesd_pkg::ST_POP : gesd_pkg::ST_EXAM;
            end
            gesd_pkg::ST_EXAM: begin
                if (flags.nb_seen || flags.out_free) begin
                    if (flags.next_null) state_next = gesd_pkg::ST_POP;
                end
            end
            gesd_pkg::ST_EMIT_LAST: begin
                if (flags.out_free) state_next = gesd_pkg::ST_IDLE;
            end
            default: state_next = gesd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            gesd_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            gesd_pkg::ST_CHECK: begin
                cmd.status_wr = 1'b1;
                if (flags.from_bad || (!flags.is_walk && flags.to_bad)) begin
                    cmd.status_code = gesd_pkg::STATUS_BAD_VERTEX;
                end else if (flags.is_walk) begin
                    cmd.status_code = gesd_pkg::STATUS_OK;
                    cmd.walk_init   = 1'b1;
                end else if (flags.table_full) begin
                    cmd.status_code = gesd_pkg::STATUS_FULL;
                end else begin
                    cmd.status_code = gesd_pkg::STATUS_OK;
                    cmd.head_rd     = 1'b1;
                    cmd.head_sel    = gesd_pkg::HSEL_FROM;
                end
            end
            gesd_pkg::ST_ADD_LINK: cmd.link = 1'b1;
            gesd_pkg::ST_ADD_RD_REV: begin
                cmd.head_rd  = 1'b1;
                cmd.head_sel = gesd_pkg::HSEL_TO;
            end
            gesd_pkg::ST_ADD_LINK_REV: begin
                cmd.link     = 1'b1;
                cmd.link_rev = 1'b1;
            end
            gesd_pkg::ST_EMIT_ONE:  cmd.emit_single = flags.out_free;
            gesd_pkg::ST_POP:       cmd.pop = !flags.stack_empty;
            gesd_pkg::ST_HEAD: begin
                cmd.head_rd  = 1'b1;
                cmd.head_sel = gesd_pkg::HSEL_CUR;
            end
            gesd_pkg::ST_FETCH:     cmd.edge_rd_head = !flags.head_null;
            gesd_pkg::ST_EXAM: begin
                if (flags.nb_seen || flags.out_free) begin
                    cmd.visit        = !flags.nb_seen;
                    cmd.edge_rd_next = !flags.next_null;
                end
            end
            gesd_pkg::ST_EMIT_LAST: cmd.emit_last = flags.out_free;
            default: begin
                cmd = '0;
            end
        endcase
    end

    `ASSERT_ALWAYS(a_reset_to_idle, aclk, !aresetn |=> state_reg == gesd_pkg::ST_IDLE, "controller not idle after reset")

endmodule

>>> sv/gesd_dp.sv
`include "assert_macros.svh"

module gesd_dp #(
    parameter int MAX_VERTICES = 16,
    parameter int MAX_EDGES    = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  gesd_pkg::cmd_t                       cmd,
    output gesd_pkg::flags_t                     flags,
    input  logic                                 s_func,
    input  logic [7:0]                           s_from_vertex,
    input  logic [7:0]                           s_to_vertex,
    input  logic [4:0]                           vertex_count,
    input  logic                                 undirected_mode,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [1:0]                           m_status,
    output logic [$clog2(MAX_VERTICES)-1:0]      m_visited_vertex,
    output logic                                 m_last,
    output logic [$clog2(MAX_EDGES+1)-1:0]       m_edge_total
);

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int DW  = $clog2(MAX_VERTICES + 1);
    localparam int CW  = $clog2(MAX_EDGES + 1);
    localparam int AW  = $clog2(MAX_EDGES);
    localparam int EWW = CW + VW;

    // Latched item
    logic            func_reg;
    logic [7:0]      from_reg;
    logic [7:0]      to_reg;
    gesd_pkg::status_t status_reg;

    logic [CW-1:0]   count_reg, count_next;
    logic [DW-1:0]   depth_reg, depth_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [VW-1:0]   pend_reg;

    // List heads: memory plus valid bits, an invalid entry reads as empty
    logic [CW-1:0]   head_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] head_vld_reg;
    logic [CW-1:0]   head_rdata_reg;
    logic            head_rvld_reg;
    logic [VW-1:0]   head_raddr;
    logic [VW-1:0]   head_waddr;

    // Edge table: {next pointer, target vertex}
    logic [EWW-1:0]  edge_mem [MAX_EDGES];
    logic [EWW-1:0]  edge_rdata_reg;
    logic [AW-1:0]   edge_raddr;
    logic            edge_re;

    logic [VW-1:0]   stack_mem [MAX_VERTICES];
    logic [VW-1:0]   stack_rdata_reg;
    logic [VW-1:0]   stack_waddr;
    logic [VW-1:0]   stack_wdata;
    logic            stack_we;
    logic [VW-1:0]   stack_raddr;

    logic            m_valid_reg;
    gesd_pkg::status_t m_status_reg;
    logic [VW-1:0]   m_vertex_reg;
    logic            m_last_reg;
    logic [CW-1:0]   m_total_reg;

    logic [VW-1:0]   from_v, to_v;
    logic [CW-1:0]   head_ptr;
    logic [CW-1:0]   next_ptr;
    logic [VW-1:0]   edge_tgt;
    logic [CW:0]     need;
    logic            out_free;
    logic            out_load;

    assign from_v   = from_reg[VW-1:0];
    assign to_v     = to_reg[VW-1:0];
    assign head_ptr = head_rvld_reg ? head_rdata_reg : CW'(MAX_EDGES);
    assign next_ptr = edge_rdata_reg[VW +: CW];
    assign edge_tgt = edge_rdata_reg[VW-1:0];
    assign need     = undirected_mode ? (CW+1)'(2) : (CW+1)'(1);
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = cmd.emit_single || cmd.emit_last || cmd.visit;

    always_comb begin
        flags.is_walk     = (func_reg == gesd_pkg::FUNC_WALK);
        flags.from_bad    = (from_reg >= {3'b000, vertex_count}) ||
                            (from_reg >= 8'(MAX_VERTICES));
        flags.to_bad      = (to_reg >= {3'b000, vertex_count}) ||
                            (to_reg >= 8'(MAX_VERTICES));
        flags.table_full  = ({1'b0, count_reg} + need) > (CW+1)'(MAX_EDGES);
        flags.undirected  = undirected_mode;
        flags.stack_empty = (depth_reg == '0);
        flags.head_null   = (head_ptr >= count_reg);
        flags.nb_seen     = visited_reg[edge_tgt];
        flags.next_null   = (next_ptr >= count_reg);
        flags.out_free    = out_free;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= s_func;
            from_reg <= s_from_vertex;
            to_reg   <= s_to_vertex;
        end
        if (cmd.status_wr) status_reg <= cmd.status_code;
    end

    // Head memory
    always_comb begin
        case (cmd.head_sel)
            gesd_pkg::HSEL_FROM: head_raddr = from_v;
            gesd_pkg::HSEL_TO:   head_raddr = to_v;
            gesd_pkg::HSEL_CUR:  head_raddr = stack_rdata_reg;
            default:             head_raddr = from_v;
        endcase
        head_waddr = cmd.link_rev ? to_v : from_v;
    end

    always_ff @(posedge aclk) begin
        if (cmd.link) head_mem[head_waddr] <= count_reg;
        if (cmd.head_rd) begin
            head_rdata_reg <= head_mem[head_raddr];
            head_rvld_reg  <= head_vld_reg[head_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_vld_reg <= '0;
        end else if (cmd.link) begin
            head_vld_reg[head_waddr] <= 1'b1;
        end
    end

    // Edge memory
    assign edge_re    = cmd.edge_rd_head || cmd.edge_rd_next;
    assign edge_raddr = cmd.edge_rd_head ? head_ptr[AW-1:0] : next_ptr[AW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.link) begin
            edge_mem[count_reg[AW-1:0]] <= {head_ptr, (cmd.link_rev ? from_v : to_v)};
        end
        if (edge_re) edge_rdata_reg <= edge_mem[edge_raddr];
    end

    // Walk stack
    assign stack_we    = cmd.walk_init || cmd.visit;
    assign stack_waddr = cmd.walk_init ? '0 : VW'(depth_reg);
    assign stack_wdata = cmd.walk_init ? from_v : edge_tgt;
    assign stack_raddr = VW'(depth_reg - DW'(1));

    always_ff @(posedge aclk) begin
        if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
        if (cmd.pop) stack_rdata_reg <= stack_mem[stack_raddr];
    end

    always_comb begin
        count_next   = count_reg;
        depth_next   = depth_reg;
        visited_next = visited_reg;
        if (cmd.link) count_next = count_reg + CW'(1);
        if (cmd.walk_init) begin
            depth_next   = DW'(1);
            visited_next = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << from_v;
        end else if (cmd.pop) begin
            depth_next = depth_reg - DW'(1);
        end else if (cmd.visit) begin
            depth_next             = depth_reg + DW'(1);
            visited_next[edge_tgt] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            depth_reg   <= '0;
            visited_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            depth_reg   <= depth_next;
            visited_reg <= visited_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Pending walk result and output register
    always_ff @(posedge aclk) begin
        if (cmd.walk_init) begin
            pend_reg <= from_v;
        end else if (cmd.visit) begin
            pend_reg <= edge_tgt;
        end
        if (cmd.emit_single) begin
            m_status_reg <= status_reg;
            m_vertex_reg <= '0;
            m_last_reg   <= 1'b1;
            m_total_reg  <= count_reg;
        end else if (cmd.visit || cmd.emit_last) begin
            m_status_reg <= gesd_pkg::STATUS_OK;
            m_vertex_reg <= pend_reg;
            m_last_reg   <= cmd.emit_last;
            m_total_reg  <= count_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_visited_vertex = m_vertex_reg;
    assign m_last           = m_last_reg;
    assign m_edge_total     = m_total_reg;

    `ASSERT_RST(a_pop_nonempty, aclk, aresetn, cmd.pop |-> depth_reg != '0, "pop from empty stack")
    `ASSERT_RST(a_link_room, aclk, aresetn, cmd.link |-> count_reg < CW'(MAX_EDGES), "link into full edge table")
    `ASSERT_RST(a_emit_slot, aclk, aresetn, out_load |-> out_free, "result loaded over a waiting result")
    `ASSERT_RST(a_emit_shows, aclk, aresetn, out_load |=> m_valid_reg, "loaded result not presented")

endmodule
